>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/scfd_pkg.sv
package scfd_pkg;

    localparam int DEFAULT_MAX_BODY_LEN = 20;

    localparam logic [7:0] START_BYTE   = 8'hF0;
    localparam logic [7:0] TYPE_STD     = 8'h84;
    localparam logic [7:0] TYPE_EXT     = 8'h86;
    localparam logic [7:0] END_BYTE     = 8'hE0;
    localparam logic [7:0] MIN_BODY_LEN = 8'd5;

    localparam int STORE_DEPTH = 12;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    typedef struct packed {
        logic        valid;
        logic [31:0] frame_id;
        logic [4:0]  payload_length;
        logic [63:0] payload;
        logic        is_extended;
    } scfd_result_t;

endpackage

>>> sv/scfd_frame_fsm.sv
module scfd_frame_fsm
    import scfd_pkg::*;
#(
    parameter int MAX_BODY_LEN = DEFAULT_MAX_BODY_LEN
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_fire,
    input  logic [7:0]   rx_byte,
    output scfd_result_t result
);

    localparam logic [2:0] STEP_HUNT = 3'd0;
    localparam logic [2:0] STEP_TYPE = 3'd1;
    localparam logic [2:0] STEP_LEN  = 3'd2;
    localparam logic [2:0] STEP_BODY = 3'd3;
    localparam logic [2:0] STEP_CHK  = 3'd4;
    localparam logic [2:0] STEP_END  = 3'd5;

    localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_BODY_LEN);

    logic [2:0] step_reg, step_next;
    logic       ext_reg, ext_next;
    logic [4:0] len_reg, len_next;
    logic [4:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [STORE_DEPTH];
    logic [7:0] store_next [STORE_DEPTH];

    always_comb
    begin
        step_next  = step_reg;
        ext_next   = ext_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        store_next = store_reg;
        result     = '0;

        case (step_reg)
            STEP_TYPE:
            begin
                if (rx_byte == TYPE_STD || rx_byte == TYPE_EXT)
                begin
                    ext_next  = (rx_byte == TYPE_EXT);
                    sum_next  = rx_byte;
                    step_next = STEP_LEN;
                end
                else
                begin
                    step_next = STEP_HUNT;
                end
            end
            STEP_LEN:
            begin
                if (rx_byte >= MIN_BODY_LEN && rx_byte <= MAX_LEN_BYTE)
                begin
                    len_next   = rx_byte[4:0];
                    idx_next   = '0;
                    store_next = '{default: 8'h00};
                    sum_next   = sum_reg + rx_byte;
                    step_next  = STEP_BODY;
                end
                else
                begin
                    step_next = STEP_HUNT;
                end
            end
            STEP_BODY:
            begin
                // bytes past the store only enter the checksum
                if (idx_reg < 5'(STORE_DEPTH))
                begin
                    store_next[idx_reg[STORE_IDX_W-1:0]] = rx_byte;
                end
                sum_next = sum_reg + rx_byte;
                idx_next = idx_reg + 5'd1;
                if (idx_next >= len_reg)
                begin
                    step_next = STEP_CHK;
                end
            end
            STEP_CHK:
            begin
                step_next = (sum_reg == rx_byte) ? STEP_END : STEP_HUNT;
            end
            STEP_END:
            begin
                if (rx_byte == END_BYTE)
                begin
                    result.valid = byte_fire;
                    for (int i = 0; i < 4; i++)
                    begin
                        result.frame_id[8*i +: 8] = store_reg[i];
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        result.payload[8*i +: 8] = store_reg[4 + i];
                    end
                    result.payload_length = len_reg - 5'd4;
                    result.is_extended    = ext_reg;
                end
                step_next = STEP_HUNT;
            end
            default:
            begin
                step_next = (rx_byte == START_BYTE) ? STEP_TYPE : STEP_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_HUNT;
            ext_reg   <= 1'b0;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            store_reg <= '{default: 8'h00};
        end
        else if (byte_fire)
        begin
            step_reg  <= step_next;
            ext_reg   <= ext_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            store_reg <= store_next;
        end
    end

endmodule

>>> sv/serial_can_frame_deframer_unit.sv
// channel  signals                    direction  payload
// in       in_valid / in_ready        input      rx_byte
// out      out_valid / out_ready      output     frame_id, payload_length, payload, is_extended
//
// one byte is taken per cycle while in_ready is high; a good frame's message appears in the cycle after its end byte
// the message sits in a single output register; bytes keep flowing while it is taken
// in_ready drops only while that register holds an item that out_ready does not take
// rst_n clears the parser to hunting and the body store to zeros at once
module serial_can_frame_deframer_unit
    import scfd_pkg::*;
#(
    parameter int MAX_BODY_LEN = DEFAULT_MAX_BODY_LEN
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] frame_id,
    output logic [4:0]  payload_length,
    output logic [63:0] payload,
    output logic        is_extended
);

    `include "assert_macros.svh"

    scfd_result_t result;
    logic         in_fire;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  frame_id_reg;
    logic [4:0]   payload_length_reg;
    logic [63:0]  payload_reg;
    logic         is_extended_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    scfd_frame_fsm #(
        .MAX_BODY_LEN(MAX_BODY_LEN)
    ) u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_fire(in_fire),
        .rx_byte  (rx_byte),
        .result   (result)
    );

    always_comb
    begin
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            frame_id_reg       <= result.frame_id;
            payload_length_reg <= result.payload_length;
            payload_reg        <= result.payload;
            is_extended_reg    <= result.is_extended;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_id       = frame_id_reg;
    assign payload_length = payload_length_reg;
    assign payload        = payload_reg;
    assign is_extended    = is_extended_reg;

    `ASSERT_CLK(a_result_needs_byte, result.valid |-> in_fire, "result without an accepted byte")
    `ASSERT_CLK(a_full_blocks_input, (out_valid_reg && !out_ready) |-> !in_ready, "input taken while output is full")
    `ASSERT_CLK(a_length_range, out_valid |-> (payload_length >= 5'd1 && payload_length <= 5'(MAX_BODY_LEN - 4)), "payload length out of range")

endmodule
